// ===== sv/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// kfd_pkg: shared constants and types for the KISS frame deframer
// Protocol byte codes, register indexes and the result record layout.
// ----------------------------------------------------------------------------
package kfd_pkg;

    // KISS protocol bytes
    localparam logic [7:0] FEND  = 8'o300;
    localparam logic [7:0] FESC  = 8'o333;
    localparam logic [7:0] TFEND = 8'o334;
    localparam logic [7:0] TFESC = 8'o335;

    // header fixup
    localparam logic [7:0] HDR_MIN   = 8'h0f;
    localparam logic [7:0] HDR_CRC_A = 8'h80;
    localparam logic [7:0] HDR_CRC_B = 8'h20;
    localparam logic [11:0] CRC_LEN  = 12'd2;

    // defaults
    localparam int          BUFFER_DEPTH_DEF = 2048;
    localparam logic [11:0] LIMIT_RESET      = 12'd2000;

    // configuration register indexes
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 12;
    localparam logic [CFG_AW-1:0] REG_RAW_MODE     = 1'd0;
    localparam logic [CFG_AW-1:0] REG_BUFFER_LIMIT = 1'd1;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DESC = 1'b1;

    // stream widths
    localparam int IN_DW  = 8;
    localparam int OUT_DW = 40;   // 39 bits of fields, padded to whole bytes

    // one result record
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [10:0] byte_index;
        logic [11:0] frame_length;
        logic [7:0]  header_byte;
        logic        last;
    } t_result;

endpackage

// ===== sv/kiss_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// kiss_frame_deframer: KISS / SLIP byte unstuffing deframer
// Strips escaping, reports stored bytes with their index and emits a frame
// descriptor at END, with optional header fixup and CRC length strip.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream, while the queue below
// has room, and gives its results on the master stream: a byte goes into an
// input register, one pass of logic decodes it against the frame state, and its
// zero, one or two results drop into a four-entry result queue. The input side
// stalls only while that queue holds more than two results. A raw-mode END that
// yields both a descriptor and a data result leaves one result of backlog that
// only input gaps or bytes with no result work off; that backlog, like a held-off
// master side, can fill the queue and stall the input. Results carry the kind in
// tuser and mark the final result of each byte in tlast.
module kiss_frame_deframer #(
    parameter int BUFFER_DEPTH = kfd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave stream; tdata: in_byte[7:0]
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [kfd_pkg::IN_DW-1:0]  s_axis_tdata,
    // master stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata: data_byte[7:0], byte_index[18:8], frame_length[30:19],
    //        header_byte[38:31], zero pad [39]
    output logic [kfd_pkg::OUT_DW-1:0] m_axis_tdata,
    output logic                       m_axis_tuser,   // result_kind
    output logic                       m_axis_tlast,   // last
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [kfd_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [kfd_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import kfd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int LIM_W = (CNT_W > CFG_DW) ? CNT_W : CFG_DW;
    localparam int QD    = 4;
    localparam int QA    = $clog2(QD);

    // configuration
    logic              r_raw;
    logic [CFG_DW-1:0] r_limit;

    // input register
    logic              r_in_vld;
    logic [7:0]        r_in_byte;

    // frame state
    logic [CNT_W-1:0]  r_fcnt, n_fcnt;
    logic              r_esc, n_esc;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_first, n_first;

    // result queue
    t_result           r_q [QD];
    logic [QA-1:0]     r_wr, r_rd;
    logic [QA:0]       r_qcnt;

    logic              w_adv;
    logic              w_pop;
    logic [1:0]        w_nres;
    t_result           w_res0, w_res1;
    logic [LIM_W-1:0]  w_lim;
    logic              w_desc_v, w_store_v;
    t_result           w_desc, w_store;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RAW_MODE:     r_raw   <= i_cfg_wdata[0];
                REG_BUFFER_LIMIT: r_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: decode a byte when the queue has room for two results
    assign w_adv         = r_in_vld && (r_qcnt <= (QA+1)'(QD - 2));
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // effective limit: smaller of the register and the buffer depth
    always_comb begin
        if (LIM_W'(r_limit) > LIM_W'(BUFFER_DEPTH)) begin
            w_lim = LIM_W'(BUFFER_DEPTH);
        end else begin
            w_lim = LIM_W'(r_limit);
        end
    end

    // descriptor from the state before this byte
    always_comb begin
        logic [11:0] len;
        logic [7:0]  hdr;
        len = 12'(r_fcnt);
        hdr = r_first;
        if (!r_raw && hdr > HDR_MIN) begin
            if ((hdr & HDR_CRC_A) != 8'h00) begin
                len = len - CRC_LEN;
                hdr = hdr & ~HDR_CRC_A;
            end else if ((hdr & HDR_CRC_B) != 8'h00) begin
                len = len - CRC_LEN;
                hdr = hdr & ~HDR_CRC_B;
            end
        end
        w_desc              = '0;
        w_desc.kind         = KIND_DESC;
        w_desc.frame_length = len;
        w_desc.header_byte  = hdr;
    end

    // byte decode and state update
    always_comb begin
        logic       store_req;
        logic [7:0] sb;
        n_fcnt    = r_fcnt;
        n_esc     = r_esc;
        n_ovf     = r_ovf;
        n_first   = r_first;
        w_desc_v  = 1'b0;
        w_store_v = 1'b0;
        store_req = 1'b0;
        sb        = r_in_byte;
        w_store   = '0;
        if (r_raw) begin
            if (r_in_byte == FEND) begin
                n_ovf = 1'b0;
                if (r_fcnt > CNT_W'(2)) begin
                    w_desc_v = !r_ovf;
                    n_fcnt   = '0;
                end
            end
            store_req = 1'b1;
        end else begin
            if (r_in_byte == FEND) begin
                w_desc_v = !r_ovf && (r_fcnt > CNT_W'(2));
                n_ovf    = 1'b0;
                n_esc    = 1'b0;
                n_fcnt   = '0;
            end else if (r_in_byte == FESC) begin
                n_esc = 1'b1;
            end else begin
                if (r_esc && r_in_byte == TFESC) begin
                    n_esc = 1'b0;
                    sb    = FESC;
                end else if (r_esc && r_in_byte == TFEND) begin
                    n_esc = 1'b0;
                    sb    = FEND;
                end
                store_req = 1'b1;
            end
        end
        // store into the frame, or flag overflow at the limit
        if (store_req && !n_ovf) begin
            if (LIM_W'(n_fcnt) < w_lim) begin
                w_store_v          = 1'b1;
                w_store.kind       = KIND_DATA;
                w_store.data_byte  = sb;
                w_store.byte_index = 11'(n_fcnt);
                if (n_fcnt == '0) begin
                    n_first = sb;
                end
                n_fcnt = n_fcnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // order results: descriptor first, last flag on the final one
    always_comb begin
        w_nres      = {1'b0, w_desc_v} + {1'b0, w_store_v};
        w_res1      = w_store;
        w_res1.last = 1'b1;
        if (w_desc_v) begin
            w_res0      = w_desc;
            w_res0.last = !w_store_v;
        end else begin
            w_res0      = w_store;
            w_res0.last = 1'b1;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_esc  <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (w_adv) begin
            r_fcnt <= n_fcnt;
            r_esc  <= n_esc;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_first <= n_first;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_adv && w_nres != 2'd0) begin
            r_q[r_wr] <= w_res0;
        end
        if (w_adv && w_nres == 2'd2) begin
            r_q[r_wr + QA'(1)] <= w_res1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (w_adv) begin
                r_wr <= r_wr + QA'(w_nres);
            end
            if (w_pop) begin
                r_rd <= r_rd + QA'(1);
            end
            r_qcnt <= r_qcnt + (w_adv ? (QA+1)'(w_nres) : '0)
                             - (QA+1)'(w_pop);
        end
    end

    // master stream
    assign m_axis_tvalid = (r_qcnt != '0);
    assign m_axis_tdata  = {1'b0, r_q[r_rd].header_byte, r_q[r_rd].frame_length,
                            r_q[r_rd].byte_index, r_q[r_rd].data_byte};
    assign m_axis_tuser  = r_q[r_rd].kind;
    assign m_axis_tlast  = r_q[r_rd].last;

    // checks
    a_qcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= (QA+1)'(QD))
        else $error("result queue count above depth");

    a_no_qovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> ((r_qcnt + (QA+1)'(w_nres)) <= (QA+1)'(QD)))
        else $error("result queue overrun");

    a_pair_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_nres == 2'd2) |-> (r_raw && r_in_byte == FEND && w_desc_v))
        else $error("two results outside a raw END");

    a_esc_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_raw && !r_esc) |=> !r_esc)
        else $error("escape set in raw mode");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_adv) |=> (r_qcnt == $past(r_qcnt) - (QA+1)'(1)))
        else $error("queue count not reduced on pop");

endmodule

// ===== tb/kiss_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// kiss_frame_deframer_tb: self-checking bench for the KISS frame deframer
// Drives received bytes on the slave stream, predicts every stored-byte and
// frame-descriptor result in a scoreboard and checks the master stream in
// order. Covers normal and raw mode, small and large limits, overflow and
// escape corner cases, with random idling on both sides.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kfd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: frame state copy, expected result queue, result check
    // ------------------------------------------------------------------------
    class t_kiss_scoreboard;
        bit          raw;
        logic [11:0] limit;
        logic [11:0] count;
        bit          esc_pend;
        bit          ovf;
        logic [7:0]  hdr0;
        t_result     exp_results[$];
        int          errors;

        function new();
            raw      = 1'b0;
            limit    = LIMIT_RESET;
            count    = '0;
            esc_pend = 1'b0;
            ovf      = 1'b0;
            hdr0     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
            if (addr == REG_RAW_MODE)
                raw = val[0];
            else if (addr == REG_BUFFER_LIMIT)
                limit = val;
        endfunction

        function int pending();
            return exp_results.size();
        endfunction

        // frame descriptor with optional header fixup and CRC strip
        function t_result descriptor();
            t_result     r;
            logic [11:0] len;
            logic [7:0]  hdr;
            len = count;
            hdr = hdr0;
            if (!raw && hdr > HDR_MIN) begin
                if ((hdr & HDR_CRC_A) != 0) begin
                    len = len - CRC_LEN;
                    hdr = hdr & ~HDR_CRC_A;
                end else if ((hdr & HDR_CRC_B) != 0) begin
                    len = len - CRC_LEN;
                    hdr = hdr & ~HDR_CRC_B;
                end
            end
            r = '0;
            r.kind = KIND_DESC;
            r.frame_length = len;
            r.header_byte = hdr;
            return r;
        endfunction

        // store one byte into the frame; returns 1 when a result is produced
        function bit store_byte(input logic [7:0] b, output t_result r);
            logic [12:0] lim;
            lim = (limit > BUFFER_DEPTH_DEF) ? 13'(BUFFER_DEPTH_DEF) : {1'b0, limit};
            r = '0;
            if (ovf)
                return 1'b0;
            if ({1'b0, count} < lim) begin
                if (count == 0)
                    hdr0 = b;
                r.kind = KIND_DATA;
                r.data_byte = b;
                r.byte_index = count[10:0];
                count = count + 1'b1;
                return 1'b1;
            end
            ovf = 1'b1;
            return 1'b0;
        endfunction

        // accepted input byte: work out its results
        function void note_byte(logic [7:0] b_in);
            t_result    step_q[$];
            t_result    r;
            logic [7:0] b;
            bit         was_over;
            b = b_in;
            if (raw) begin
                if (b == FEND) begin
                    was_over = ovf;
                    ovf = 1'b0;
                    if (count > 2) begin
                        if (!was_over)
                            step_q.push_back(descriptor());
                        count = '0;
                    end
                end
                if (store_byte(b, r))
                    step_q.push_back(r);
            end else begin
                if (b == FEND) begin
                    if (!ovf && count > 2)
                        step_q.push_back(descriptor());
                    ovf = 1'b0;
                    esc_pend = 1'b0;
                    count = '0;
                end else if (b == FESC) begin
                    esc_pend = 1'b1;
                end else begin
                    if (b == TFESC && esc_pend) begin
                        esc_pend = 1'b0;
                        b = FESC;
                    end else if (b == TFEND && esc_pend) begin
                        esc_pend = 1'b0;
                        b = FEND;
                    end
                    if (store_byte(b, r))
                        step_q.push_back(r);
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i])
                exp_results.push_back(step_q[i]);
        endfunction

        function void mismatch(string what, t_result e, t_result g);
            errors++;
            if (errors <= 10)
                $display({"%0t mismatch (%s): exp kind=%0d data=%h idx=%0d len=%0d",
                          " hdr=%h last=%0d | got kind=%0d data=%h idx=%0d len=%0d",
                          " hdr=%h last=%0d"},
                         $realtime, what, e.kind, e.data_byte, e.byte_index, e.frame_length,
                         e.header_byte, e.last, g.kind, g.data_byte, g.byte_index,
                         g.frame_length, g.header_byte, g.last);
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(logic kind, logic [OUT_DW-1:0] tdata, logic last);
            t_result g;
            t_result e;
            g.kind = kind;
            g.data_byte = tdata[7:0];
            g.byte_index = tdata[18:8];
            g.frame_length = tdata[30:19];
            g.header_byte = tdata[38:31];
            g.last = last;
            if (exp_results.size() == 0) begin
                mismatch("unexpected result", '0, g);
                return;
            end
            e = exp_results.pop_front();
            if (g.kind !== e.kind || g.data_byte !== e.data_byte ||
                g.byte_index !== e.byte_index || g.frame_length !== e.frame_length ||
                g.header_byte !== e.header_byte || g.last !== e.last)
                mismatch("field", e, g);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;

    t_kiss_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent           = 0;

    kiss_frame_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (called and returning at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    // hold off the sender until every expected result is in
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // register write while idle; bytes with no result may still be in flight
    task automatic program_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        sb.write_reg(addr, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default:   begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endfunction

    function automatic int max_frame_len();
        return (sb.limit < 40) ? int'(sb.limit) + 3 : 30;
    endfunction

    // escaped frame with random payload, closed by END
    task automatic send_normal_frame(int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0:       b = FEND;
                1:       b = FESC;
                2:       b = ($urandom_range(1)) ? TFEND : TFESC;
                default: b = 8'($urandom_range(255));
            endcase
            // stray escape followed by an ordinary byte
            if ($urandom_range(19) == 0) begin
                send_byte(FESC);
                send_byte(8'($urandom_range(8'hbf)));
            end
            if (b == FEND) begin
                send_byte(FESC);
                send_byte(TFEND);
            end else if (b == FESC) begin
                send_byte(FESC);
                send_byte(TFESC);
            end else begin
                send_byte(b);
            end
        end
        send_byte(FEND);
    endtask

    // raw run: random bytes, END frequent, closed by END
    task automatic send_raw_run(int len);
        for (int i = 0; i < len; i++)
            send_byte(($urandom_range(5) == 0) ? FEND : 8'($urandom_range(255)));
        send_byte(FEND);
    endtask

    // short burst of noise, heavy on protocol bytes
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(4))
                0:       send_byte(FEND);
                1:       send_byte(FESC);
                2:       send_byte(TFEND);
                3:       send_byte(TFESC);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    // long frame without protocol bytes in the payload
    task automatic send_long_frame(int len, logic [7:0] hdr);
        send_byte(hdr);
        for (int i = 1; i < len; i++)
            send_byte(8'($urandom_range(8'hbf)));
        send_byte(FEND);
    endtask

    task automatic run_random_phase(bit raw, logic [11:0] lim, t_idle_mode mode,
                                    int n_items, bit pause);
        int  start;
        bit  paused;
        program_reg(REG_RAW_MODE, {11'd0, raw});
        program_reg(REG_BUFFER_LIMIT, lim);
        set_idle(mode);
        start  = sent;
        paused = 1'b0;
        while (sent - start < n_items) begin
            if (pause && !paused && sent - start >= n_items / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(7) == 0)
                send_noise();
            else if (raw)
                send_raw_run($urandom_range(max_frame_len()));
            else
                send_normal_frame($urandom_range(max_frame_len()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [7:0] normal_dir[] = '{
        FEND,
        8'hff, FESC, TFEND, FESC, TFESC, 8'h00, FEND,   // bit 7 header, both escapes
        8'h25, 8'h01, 8'h02, FEND,                      // bit 5 header
        8'h0f, FESC, 8'h41, TFEND, FEND,                // low header, escape then other byte
        8'h11, 8'h22, FEND,                             // two bytes: no descriptor
        FESC, FEND, TFEND, FEND                         // END clears a pending escape
    };
    logic [7:0] raw_dir[] = '{
        FEND, FESC, TFESC, FEND,                        // descriptor then stored END
        8'h01, 8'h02, 8'h03, FEND,                      // overflow, END clears it
        8'hff, 8'h00, 8'h7e, FEND
    };
    logic [11:0] lim;

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: normal mode at reset settings, then raw mode at the lowest limit
        foreach (normal_dir[i])
            send_byte(normal_dir[i]);
        program_reg(REG_RAW_MODE, 12'd1);
        program_reg(REG_BUFFER_LIMIT, 12'd3);
        foreach (raw_dir[i])
            send_byte(raw_dir[i]);

        // random phases over modes, limits and idling
        for (int p = 0; p < 12; p++) begin
            case ((p + p / 4) % 4)
                0:       lim = 12'd3;
                1:       lim = 12'd2048;
                2:       lim = 12'($urandom_range(4, 40));
                default: lim = LIMIT_RESET;
            endcase
            run_random_phase(p[0], lim, t_idle_mode'(p % 4), 95, (p == 5 || p == 10));
        end

        // frame exactly at the limit, then one that overflows
        program_reg(REG_RAW_MODE, 12'd0);
        program_reg(REG_BUFFER_LIMIT, 12'd40);
        set_idle(IDLE_BOTH);
        send_long_frame(40, 8'h05);
        send_long_frame(42, 8'ha5);

        // limit register above the buffer depth
        program_reg(REG_BUFFER_LIMIT, 12'hfff);
        send_normal_frame(5);

        // wind down
        drain();
        repeat (10) @(negedge i_clk);
        while (sb.pending() != 0) begin
            sb.mismatch("missing result", sb.exp_results.pop_front(), '0);
        end
        if (sb.errors == 0)
            $display("PASS kiss_frame_deframer");
        else
            $display("FAIL kiss_frame_deframer");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAIL kiss_frame_deframer");
        $finish;
    end

endmodule
